// ===== src/gmcps_pkg.sv =====
// ----------------------------------------------------------------------------
// gmcps_pkg
// Shared types and constants for the grid minimum-cost path search unit.
// ----------------------------------------------------------------------------
package gmcps_pkg;

  localparam int unsigned GRID_DIM   = 8;
  localparam int unsigned CELL_COUNT = GRID_DIM * GRID_DIM;
  localparam logic [1:0]  COST_UP    = 2'd3;
  localparam logic [1:0]  COST_SIDE  = 2'd1;
  localparam logic [1:0]  COST_DOWN  = 2'd0;
  localparam logic [7:0]  NO_BEST    = 8'hFF;

  // configuration register indexes
  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_COLS  = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  // opcodes
  localparam logic OPC_LOAD  = 1'b0;
  localparam logic OPC_SOLVE = 1'b1;

  // neighbour order
  localparam logic [2:0] DIR_UP    = 3'd0;
  localparam logic [2:0] DIR_RIGHT = 3'd1;
  localparam logic [2:0] DIR_DOWN  = 3'd2;
  localparam logic [2:0] DIR_LEFT  = 3'd3;
  localparam logic [2:0] DIR_DONE  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_ENTER, S_EXPAND, S_POP, S_POPW, S_COPY, S_ERD, S_EOUT
  } state_t;

  // datapath command
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_INIT, OP_ENTER, OP_EXPAND, OP_POP, OP_POPW,
    OP_COPY, OP_ERD, OP_EOUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic is_exit;
    logic accept;
    logic prune;
    logic dir_done;
    logic push_ok;
    logic last_pop;
    logic copy_done;
    logic out_xfer;
    logic out_last;
  } status_t;

  // cost of a move between rows
  function automatic logic [1:0] move_cost(input logic [2:0] fr, input logic [2:0] tr);
    logic [1:0] c;
    if (tr < fr) c = COST_UP;
    else if (tr > fr) c = COST_DOWN;
    else c = COST_SIDE;
    return c;
  endfunction

endpackage

// ===== src/gmcps_ctrl.sv =====
// ----------------------------------------------------------------------------
// gmcps_ctrl
// Sequencer for loads, the backtracking search, best-path copy and emission.
// ----------------------------------------------------------------------------
module gmcps_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             opcode,
  output logic             item_stall,
  input  gmcps_pkg::status_t sts,
  output gmcps_pkg::cmd_t  cmd
);

  gmcps_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= gmcps_pkg::S_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gmcps_pkg::S_IDLE: begin
        if (item_valid && opcode == gmcps_pkg::OPC_SOLVE) state_next = gmcps_pkg::S_INIT;
      end
      gmcps_pkg::S_INIT:  state_next = gmcps_pkg::S_ENTER;
      gmcps_pkg::S_ENTER: begin
        if (sts.is_exit) state_next = sts.accept ? gmcps_pkg::S_COPY : gmcps_pkg::S_POP;
        else             state_next = sts.prune ? gmcps_pkg::S_POP : gmcps_pkg::S_EXPAND;
      end
      gmcps_pkg::S_EXPAND: begin
        if (sts.dir_done)     state_next = gmcps_pkg::S_POP;
        else if (sts.push_ok) state_next = gmcps_pkg::S_ENTER;
      end
      gmcps_pkg::S_POP:  state_next = sts.last_pop ? gmcps_pkg::S_ERD : gmcps_pkg::S_POPW;
      gmcps_pkg::S_POPW: state_next = gmcps_pkg::S_EXPAND;
      gmcps_pkg::S_COPY: begin
        if (sts.copy_done) state_next = gmcps_pkg::S_POP;
      end
      gmcps_pkg::S_ERD:  state_next = gmcps_pkg::S_EOUT;
      gmcps_pkg::S_EOUT: begin
        if (sts.out_xfer) state_next = sts.out_last ? gmcps_pkg::S_IDLE : gmcps_pkg::S_ERD;
      end
      default: state_next = gmcps_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item_stall = 1'b1;
    cmd.op     = gmcps_pkg::OP_NONE;
    case (state)
      gmcps_pkg::S_IDLE: begin
        item_stall = 1'b0;
        if (item_valid && opcode == gmcps_pkg::OPC_LOAD) cmd.op = gmcps_pkg::OP_LOAD;
      end
      gmcps_pkg::S_INIT:   cmd.op = gmcps_pkg::OP_INIT;
      gmcps_pkg::S_ENTER:  cmd.op = gmcps_pkg::OP_ENTER;
      gmcps_pkg::S_EXPAND: cmd.op = gmcps_pkg::OP_EXPAND;
      gmcps_pkg::S_POP:    cmd.op = gmcps_pkg::OP_POP;
      gmcps_pkg::S_POPW:   cmd.op = gmcps_pkg::OP_POPW;
      gmcps_pkg::S_COPY:   cmd.op = gmcps_pkg::OP_COPY;
      gmcps_pkg::S_ERD:    cmd.op = gmcps_pkg::OP_ERD;
      gmcps_pkg::S_EOUT:   cmd.op = gmcps_pkg::OP_EOUT;
      default:             cmd.op = gmcps_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== src/gmcps_dpath.sv =====
// ----------------------------------------------------------------------------
// gmcps_dpath
// Grid maps, path stack and best-path memories, cost tracking, result register.
// ----------------------------------------------------------------------------
module gmcps_dpath (
  input  logic             clk,
  input  logic             rst,
  input  gmcps_pkg::cmd_t  cmd,
  output gmcps_pkg::status_t sts,
  input  logic [2:0]       cell_row,
  input  logic [2:0]       cell_col,
  input  logic             cell_open,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  input  logic             result_stall,
  output logic             result_valid,
  output logic             found,
  output logic [2:0]       path_row,
  output logic [2:0]       path_col,
  output logic [7:0]       path_cost,
  output logic             last
);

  logic [3:0] grid_rows, grid_cols;
  logic [7:0] energy_limit;
  logic [63:0] open_map, visited;
  logic [5:0] cur_cell;
  logic [2:0] cur_dir;
  logic [6:0] depth;
  logic [8:0] cost;
  logic [6:0] best_len;
  logic [7:0] best_cost;
  logic [6:0] k;

  logic [8:0] stack_mem [64];
  logic [5:0] best_mem  [64];
  logic [8:0] stack_rd;
  logic [5:0] best_rd;

  logic [3:0] rows_c, cols_c;
  logic [2:0] r, c, nr;
  logic [5:0] nb;
  logic       nb_ok;
  logic [7:0] bound;
  logic [9:0] need;
  logic [6:0] depth_m2;
  logic [5:0] stack_ra;
  logic [6:0] best_len_m1;
  logic       out_xfer;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows    <= 4'd8;
      grid_cols    <= 4'd8;
      energy_limit <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        gmcps_pkg::REG_ROWS:  grid_rows    <= cfg_data[3:0];
        gmcps_pkg::REG_COLS:  grid_cols    <= cfg_data[3:0];
        gmcps_pkg::REG_LIMIT: energy_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped grid size
  assign rows_c = (grid_rows == 4'd0) ? 4'd1 : ((grid_rows > 4'd8) ? 4'd8 : grid_rows);
  assign cols_c = (grid_cols == 4'd0) ? 4'd1 : ((grid_cols > 4'd8) ? 4'd8 : grid_cols);

  assign r = cur_cell[5:3];
  assign c = cur_cell[2:0];

  // neighbour of the current direction
  always_comb begin
    nb    = cur_cell;
    nb_ok = 1'b0;
    case (cur_dir)
      gmcps_pkg::DIR_UP: begin
        nb_ok = (r != 3'd0);
        nb    = cur_cell - 6'd8;
      end
      gmcps_pkg::DIR_RIGHT: begin
        nb_ok = ({1'b0, c} + 4'd1) < cols_c;
        nb    = cur_cell + 6'd1;
      end
      gmcps_pkg::DIR_DOWN: begin
        nb_ok = ({1'b0, r} + 4'd1) < rows_c;
        nb    = cur_cell + 6'd8;
      end
      gmcps_pkg::DIR_LEFT: begin
        nb_ok = (c != 3'd0);
        nb    = cur_cell - 6'd1;
      end
      default: nb_ok = 1'b0;
    endcase
  end
  assign nr = nb[5:3];

  // bound and remaining-cost estimate
  assign bound = (best_len != 7'd0 && best_cost < energy_limit) ? best_cost : energy_limit;
  assign need  = {1'b0, cost} + {6'd0, cols_c - 4'd1 - {1'b0, c}}
               + {5'd0, r, 2'd0} - {7'd0, r} ;
  // 4r - r = 3r

  assign depth_m2    = depth - 7'd2;
  assign stack_ra    = (cmd.op == gmcps_pkg::OP_COPY) ? k[5:0] : depth_m2[5:0];
  assign best_len_m1 = best_len - 7'd1;
  assign out_xfer    = result_valid && !result_stall;

  // status to the controller
  always_comb begin
    sts.is_exit   = (r == 3'd0) && ({1'b0, c} == cols_c - 4'd1);
    sts.accept    = cost < {1'b0, bound};
    sts.prune     = need >= {2'd0, bound};
    sts.dir_done  = cur_dir >= gmcps_pkg::DIR_DONE;
    sts.push_ok   = nb_ok && open_map[nb] && !visited[nb] && depth < 7'd64;
    sts.last_pop  = depth == 7'd1;
    sts.copy_done = k == depth;
    sts.out_xfer  = out_xfer;
    sts.out_last  = last;
  end

  // memories with registered reads
  always_ff @(posedge clk) begin
    stack_rd <= stack_mem[stack_ra];
    best_rd  <= best_mem[k[5:0]];
    if (cmd.op == gmcps_pkg::OP_EXPAND && sts.push_ok && !sts.dir_done) begin
      stack_mem[depth_m2[5:0] + 6'd1] <= {cur_cell, cur_dir + 3'd1};
    end
    if (cmd.op == gmcps_pkg::OP_COPY && k != 7'd0) begin
      best_mem[k[5:0] - 6'd1] <= (k == depth) ? cur_cell : stack_rd[8:3];
    end
  end

  // grid maps
  always_ff @(posedge clk) begin
    if (rst) begin
      open_map <= '0;
      visited  <= '0;
    end else begin
      case (cmd.op)
        gmcps_pkg::OP_LOAD: open_map[{cell_row, cell_col}] <= cell_open;
        gmcps_pkg::OP_INIT: visited <= 64'd1;
        gmcps_pkg::OP_EXPAND: begin
          if (!sts.dir_done && sts.push_ok) visited[nb] <= 1'b1;
        end
        gmcps_pkg::OP_POP: begin
          if (depth > 7'd1) visited[cur_cell] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // search state
  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      cost      <= '0;
      best_len  <= '0;
      best_cost <= gmcps_pkg::NO_BEST;
      k         <= '0;
      cur_cell  <= '0;
      cur_dir   <= '0;
    end else begin
      case (cmd.op)
        gmcps_pkg::OP_INIT: begin
          best_len  <= '0;
          best_cost <= gmcps_pkg::NO_BEST;
          cost      <= '0;
          cur_cell  <= '0;
          depth     <= 7'd1;
        end
        gmcps_pkg::OP_ENTER: begin
          cur_dir <= '0;
          k       <= '0;
          if (sts.is_exit && sts.accept) begin
            best_len  <= depth;
            best_cost <= cost[7:0];
          end
        end
        gmcps_pkg::OP_EXPAND: begin
          if (!sts.dir_done) begin
            cur_dir <= cur_dir + 3'd1;
            if (sts.push_ok) begin
              cost     <= cost + {7'd0, gmcps_pkg::move_cost(r, nr)};
              cur_cell <= nb;
              depth    <= depth + 7'd1;
            end
          end
        end
        gmcps_pkg::OP_POP: begin
          depth <= depth - 7'd1;
          k     <= '0;
        end
        gmcps_pkg::OP_POPW: begin
          cost     <= cost - {7'd0, gmcps_pkg::move_cost(stack_rd[8:6], r)};
          cur_cell <= stack_rd[8:3];
          cur_dir  <= stack_rd[2:0];
        end
        gmcps_pkg::OP_COPY: k <= k + 7'd1;
        gmcps_pkg::OP_EOUT: begin
          if (out_xfer) k <= k + 7'd1;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.op == gmcps_pkg::OP_EOUT) begin
      if (!result_valid) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == gmcps_pkg::OP_EOUT && !result_valid) begin
      if (best_len == 7'd0) begin
        found     <= 1'b0;
        path_row  <= '0;
        path_col  <= '0;
        path_cost <= '0;
        last      <= 1'b1;
      end else begin
        found     <= 1'b1;
        path_row  <= best_rd[5:3];
        path_col  <= best_rd[2:0];
        path_cost <= best_cost;
        last      <= (k == best_len_m1);
      end
    end
  end

endmodule

// ===== src/grid_min_cost_path_search_unit.sv =====
// ----------------------------------------------------------------------------
// grid_min_cost_path_search_unit
// Exhaustive backtracking minimum-cost path search over an open/closed grid of up to 8x8 cells.
// ----------------------------------------------------------------------------
// A load item writes one grid cell. A solve item holds item_stall high for
// the whole search: each tried neighbour, each cell found with its directions
// exhausted, each entered cell and each backtrack (pop, then path stack read)
// has its own state step, and each new best path is copied cell by cell into
// the best-path memory; the total grows with the number of simple paths
// explored. The best path is then emitted one result per cell, each through a
// best-path memory read, a result register load, then the transfer, and the
// next read starts only once that transfer is done; or a single result with
// found low if none exists.
module grid_min_cost_path_search_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       opcode,
  input  logic [2:0] cell_row,
  input  logic [2:0] cell_col,
  input  logic       cell_open,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       found,
  output logic [2:0] path_row,
  output logic [2:0] path_col,
  output logic [7:0] path_cost,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  gmcps_pkg::cmd_t    cmd;
  gmcps_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  gmcps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .opcode     (opcode),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  gmcps_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cell_row     (cell_row),
    .cell_col     (cell_col),
    .cell_open    (cell_open),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .found        (found),
    .path_row     (path_row),
    .path_col     (path_col),
    .path_cost    (path_cost),
    .last         (last)
  );

  // a solve transfer blocks further input
  a_solve_stalls: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && opcode == gmcps_pkg::OPC_SOLVE |=> item_stall)
    else $error("input not stalled after solve");

  // results only appear while input is held off
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("result pending while input open");

  // nothing follows the final result of a solve
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && last |=> !result_valid)
    else $error("result after last");

endmodule
